// ----- hw/rtl/vt4_pkg.sv -----
// Shared types and constants for the 4x4 vertex transform core.
// No dependencies; every other file in hw/rtl imports this package.
package vt4_pkg;

   localparam int DATA_WIDTH_DEF = 32;
   localparam int COEF_WIDTH_DEF = 16;
   localparam int PORT_WIDTH     = 32;
   localparam int COEF_SLOT      = 16;
   localparam int DIM            = 4;
   localparam int CSR_DATA_WIDTH = 64;
   localparam int CSR_ADDR_WIDTH = 5;
   localparam int CSR_IDX_LSB    = 3;
   localparam int PIPE_DEPTH     = 5;

   // Identity matrix, Q4.12 ones on the diagonal
   localparam logic [DIM-1:0][CSR_DATA_WIDTH-1:0] COL_RESET = {
      64'h1000_0000_0000_0000,
      64'h0000_1000_0000_0000,
      64'h0000_0000_1000_0000,
      64'h0000_0000_0000_1000
   };

   typedef struct packed {
      logic signed [PORT_WIDTH-1:0] in_x;
      logic signed [PORT_WIDTH-1:0] in_y;
      logic signed [PORT_WIDTH-1:0] in_z;
      logic signed [PORT_WIDTH-1:0] in_w;
   } vt4_req_type;

   typedef struct packed {
      logic signed [PORT_WIDTH-1:0] out_x;
      logic signed [PORT_WIDTH-1:0] out_y;
      logic signed [PORT_WIDTH-1:0] out_z;
      logic signed [PORT_WIDTH-1:0] out_w;
      logic                         saturated;
   } vt4_rsp_type;

   typedef logic [DIM-1:0][CSR_DATA_WIDTH-1:0] vt4_matrix_type;
   typedef logic [DIM-1:0][PORT_WIDTH-1:0]     vt4_vec_type;

endpackage

// ----- hw/rtl/vt4_csr.sv -----
// Matrix register file with an APB-style access port.
// Depends on vt4_pkg for widths, register count and reset values.
module vt4_csr import vt4_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready,
   output vt4_matrix_type            matrix
);

   vt4_matrix_type col_ff;
   vt4_matrix_type col_in;
   logic [CSR_ADDR_WIDTH-CSR_IDX_LSB-1:0] idx;

   assign idx    = paddr[CSR_ADDR_WIDTH-1:CSR_IDX_LSB];
   assign pready = 1'b1;
   assign prdata = col_ff[idx];
   assign matrix = col_ff;

   always_comb begin
      col_in = col_ff;
      if (psel && penable && pwrite && pready) begin
         col_in[idx] = pwdata;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         col_ff <= COL_RESET;
      end else begin
         col_ff <= col_in;
      end
   end

endmodule

// ----- hw/rtl/vt4_lane.sv -----
// One output component: four multipliers, a two-level adder tree,
// round half up and saturate, four register stages. Depends on vt4_pkg.
module vt4_lane import vt4_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  logic                      clock,
   input  vt4_vec_type               vec,
   input  logic [CSR_DATA_WIDTH-1:0] coef_col,
   output logic [PORT_WIDTH-1:0]     result,
   output logic                      sat
);

   localparam int PB   = (DATA_WIDTH < PORT_WIDTH) ? DATA_WIDTH : PORT_WIDTH;
   localparam int FRAC = COEF_WIDTH - 4;
   localparam int PW   = PB + COEF_WIDTH;
   localparam int SW   = PW + 2;
   localparam int RW   = SW - FRAC;

   localparam logic signed [SW-1:0] HALF = {{(SW-1){1'b0}}, 1'b1} << (FRAC - 1);
   localparam logic signed [RW-1:0] MAXV = RW'({1'b0, {(PB-1){1'b1}}});
   localparam logic signed [RW-1:0] MINV = ~MAXV;

   logic signed [PW-1:0]   prod_in [DIM];
   logic signed [PW-1:0]   prod_ff [DIM];
   logic signed [PW:0]     pair_in [2];
   logic signed [PW:0]     pair_ff [2];
   logic signed [SW-1:0]   sum_in;
   logic signed [RW-1:0]   round_ff;
   logic signed [PB-1:0]   clamp_in;
   logic                   sat_in;
   logic [PORT_WIDTH-1:0]  result_in;
   logic [PORT_WIDTH-1:0]  result_ff;
   logic                   sat_ff;

   // Stage 1: one product per matrix entry of this column
   always_comb begin
      for (int i = 0; i < DIM; i++) begin
         prod_in[i] = $signed(vec[i][PB-1:0])
                    * $signed(coef_col[i*COEF_SLOT +: COEF_WIDTH]);
      end
   end

   // Stage 2: pairwise sums
   always_comb begin
      pair_in[0] = (PW+1)'(prod_ff[0]) + (PW+1)'(prod_ff[1]);
      pair_in[1] = (PW+1)'(prod_ff[2]) + (PW+1)'(prod_ff[3]);
   end

   // Stage 3: final sum plus half an output LSB, drop the fraction bits
   assign sum_in = SW'(pair_ff[0]) + SW'(pair_ff[1]) + HALF;

   // Stage 4: clamp to the data range
   always_comb begin
      sat_in   = 1'b0;
      clamp_in = round_ff[PB-1:0];
      priority if (round_ff > MAXV) begin
         clamp_in = MAXV[PB-1:0];
         sat_in   = 1'b1;
      end else if (round_ff < MINV) begin
         clamp_in = MINV[PB-1:0];
         sat_in   = 1'b1;
      end
      result_in = PORT_WIDTH'(clamp_in);
   end

   always_ff @(posedge clock) begin
      prod_ff   <= prod_in;
      pair_ff   <= pair_in;
      round_ff  <= sum_in[SW-1:FRAC];
      result_ff <= result_in;
      sat_ff    <= sat_in;
   end

   assign result = result_ff;
   assign sat    = sat_ff;

endmodule

// ----- hw/rtl/vertex_transform_4x4_core.sv -----
// Vertex transform core: row vector (x,y,z,w) times a 4x4 Q4.12 matrix.
// rsp_strobe rises once a request has passed the vector register and the lane registers.
// Throughput: one request per clock; sixteen multipliers, one per matrix entry.
// busy stays low: every stage advances each cycle and the receiver cannot stall.
// Reset (synchronous): flush the valid chain, load the identity matrix.
// Depends on vt4_pkg, vt4_csr and vt4_lane.
module vertex_transform_4x4_core import vt4_pkg::*; #(
   parameter int DATA_WIDTH = DATA_WIDTH_DEF,
   parameter int COEF_WIDTH = COEF_WIDTH_DEF
) (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      start,
   output logic                      busy,
   input  vt4_req_type               req_data,
   // result channel
   output logic                      rsp_strobe,
   output vt4_rsp_type               rsp_data,
   // configuration port
   input  logic                      psel,
   input  logic                      penable,
   input  logic                      pwrite,
   input  logic [CSR_ADDR_WIDTH-1:0] paddr,
   input  logic [CSR_DATA_WIDTH-1:0] pwdata,
   output logic [CSR_DATA_WIDTH-1:0] prdata,
   output logic                      pready
);

   vt4_matrix_type          matrix;
   vt4_vec_type             vec_ff;
   vt4_vec_type             vec_in;
   logic [PIPE_DEPTH-1:0]   valid_ff;
   logic [PIPE_DEPTH-1:0]   valid_in;
   logic                    accept;
   logic [PORT_WIDTH-1:0]   lane_result [DIM];
   logic [DIM-1:0]          lane_sat;

   // No back-pressure anywhere in the pipe
   assign busy   = 1'b0;
   assign accept = start && !busy;

   vt4_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .matrix  (matrix)
   );

   // Stage 0: capture the request vector, component 0 in slot 0
   always_comb begin
      vec_in    = vec_ff;
      if (accept) begin
         vec_in[0] = req_data.in_x;
         vec_in[1] = req_data.in_y;
         vec_in[2] = req_data.in_z;
         vec_in[3] = req_data.in_w;
      end
   end

   always_ff @(posedge clock) begin
      vec_ff <= vec_in;
   end

   // Valid bit travels alongside the data, one bit per stage
   assign valid_in = {valid_ff[PIPE_DEPTH-2:0], accept};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   // Stages 1..4: one lane per output component, each reads its matrix column
   for (genvar j = 0; j < DIM; j++) begin : g_lane
      vt4_lane #(
         .DATA_WIDTH (DATA_WIDTH),
         .COEF_WIDTH (COEF_WIDTH)
      ) u_lane (
         .clock    (clock),
         .vec      (vec_ff),
         .coef_col (matrix[j]),
         .result   (lane_result[j]),
         .sat      (lane_sat[j])
      );
   end

   // Drive the result straight from the lane output registers
   assign rsp_strobe         = valid_ff[PIPE_DEPTH-1];
   assign rsp_data.out_x     = lane_result[0];
   assign rsp_data.out_y     = lane_result[1];
   assign rsp_data.out_z     = lane_result[2];
   assign rsp_data.out_w     = lane_result[3];
   assign rsp_data.saturated = |lane_sat;

endmodule
